### rtl/rfw_pkg.sv
`default_nettype none

package rfw_pkg;

  localparam int HDR_LEN = 7;
  localparam int ID_LEN  = 5;

  localparam logic [1:0] REQ_CHECK  = 2'd0;
  localparam logic [1:0] REQ_ENROLL = 2'd1;

  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_GRANTED  = 3'd1,
    ST_DENIED   = 3'd2,
    ST_ENROLLED = 3'd3,
    ST_FULL     = 3'd4,
    ST_DISCARD  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [1:0] req_type;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  entry_index;
    logic [39:0] card_id;
  } result_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h04;
      3'd1:    b = 8'h0C;
      3'd2:    b = 8'h02;
      3'd3:    b = 8'h30;
      3'd4:    b = 8'h00;
      3'd5:    b = 8'h04;
      3'd6:    b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/rfid_frame_id_whitelist.sv
// Header bytes, the first four ID bytes, enroll and discard give their result in the cycle
// after the byte is accepted. A check request waits for the table scan, which reads one
// entry per cycle from one port and ends at the first match or at entry last_entry.
// Throughput: one byte per cycle outside a scan; busy stays high during a scan.
// Reset clears the header matcher, the ID byte count and the table fill count at once.
// The receiver cannot stall: each result is shown for exactly one cycle with done high.
`default_nettype none

module rfid_frame_id_whitelist
  import rfw_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire cmd_t    cmd,
  output logic         done,
  output result_t      result
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t          state;
  logic [2:0]      header_pos;
  logic [2:0]      id_byte_count;
  logic [31:0]     id_sr;
  logic [39:0]     id_reg;
  logic [IW-1:0]   last_entry;
  logic [IW:0]     rd_cnt;
  logic [IW-1:0]   q_idx;
  logic            q_valid;
  logic [39:0]     mem_q;
  logic [39:0]     id_table [TABLE_ENTRIES];

  logic            accept;
  logic [39:0]     id_full;
  logic [IW-1:0]   le_next;
  logic            table_full;
  logic            issuing;
  logic            hit;
  logic            enroll_we;
  logic [IW+3:0]   le_next_ext;
  logic [IW+3:0]   q_idx_ext;

  assign busy        = (state != S_IDLE);
  assign accept      = start && (state == S_IDLE);
  assign id_full     = {id_sr, cmd.rx_byte};
  assign le_next     = last_entry + IW'(1);
  assign table_full  = (last_entry == IW'(TABLE_ENTRIES - 1));
  assign issuing     = (rd_cnt <= {1'b0, last_entry});
  assign hit         = q_valid && ((q_idx == '0) ? (id_reg == '0) : (mem_q == id_reg));
  assign le_next_ext = {4'b0000, le_next};
  assign q_idx_ext   = {4'b0000, q_idx};
  assign enroll_we   = accept && (header_pos == 3'(HDR_LEN))
                       && (id_byte_count == 3'(ID_LEN - 1))
                       && (cmd.req_type == REQ_ENROLL) && !table_full;

  always_ff @(posedge clk) begin
    if (enroll_we) begin
      id_table[le_next] <= id_full;
    end
    mem_q <= id_table[rd_cnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      header_pos    <= '0;
      id_byte_count <= '0;
      last_entry    <= '0;
      rd_cnt        <= '0;
      q_valid       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            result.status      <= ST_PENDING;
            result.entry_index <= '0;
            result.card_id     <= '0;
            if (header_pos != 3'(HDR_LEN)) begin
              done <= 1'b1;
              if (cmd.rx_byte == hdr_byte(header_pos)) begin
                header_pos <= header_pos + 3'd1;
              end else begin
                header_pos <= '0;
              end
            end else begin
              id_sr <= id_full[31:0];
              if (id_byte_count == 3'(ID_LEN - 1)) begin
                id_byte_count  <= '0;
                header_pos     <= '0;
                id_reg         <= id_full;
                result.card_id <= id_full;
                case (cmd.req_type)
                  REQ_CHECK: begin
                    state   <= S_SCAN;
                    rd_cnt  <= '0;
                    q_valid <= 1'b0;
                  end
                  REQ_ENROLL: begin
                    done <= 1'b1;
                    if (!table_full) begin
                      last_entry         <= le_next;
                      result.status      <= ST_ENROLLED;
                      result.entry_index <= le_next_ext[3:0];
                    end else begin
                      result.status <= ST_FULL;
                    end
                  end
                  default: begin
                    done          <= 1'b1;
                    result.status <= ST_DISCARD;
                  end
                endcase
              end else begin
                done          <= 1'b1;
                id_byte_count <= id_byte_count + 3'd1;
              end
            end
          end
        end
        S_SCAN: begin
          q_valid <= issuing;
          q_idx   <= rd_cnt[IW-1:0];
          if (issuing) begin
            rd_cnt <= rd_cnt + (IW+1)'(1);
          end
          if (hit) begin
            state              <= S_IDLE;
            done               <= 1'b1;
            result.status      <= ST_GRANTED;
            result.entry_index <= q_idx_ext[3:0];
          end else if (q_valid && (q_idx == last_entry)) begin
            state              <= S_IDLE;
            done               <= 1'b1;
            result.status      <= ST_DENIED;
            result.entry_index <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### dv/rfid_frame_id_whitelist_test.sv
`timescale 1ns / 1ps

module rfid_frame_id_whitelist_test;
  import rfw_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [1:0] REQ_DISCARD = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [HDR_LEN*8-1:0] FRAME_HDR = 56'h04_0C_02_30_00_04_00;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic done;
  cmd_t cmd;
  result_t result;

  int hdr_pos = 0;
  int id_cnt = 0;
  int store_top = 0;
  logic [7:0] id_bytes [ID_LEN];
  logic [39:0] id_store [TABLE_ENTRIES];
  logic [39:0] known_ids [$];
  result_t reply_fifo [$];

  int errors = 0;
  int cycle_count = 0;
  int accepted_beats = 0;
  int sender_idle_pct = 0;
  int status_seen [6];

  rfid_frame_id_whitelist #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] hdr_at(int k);
    return FRAME_HDR[(HDR_LEN - 1 - k) * 8 +: 8];
  endfunction

  function automatic result_t whitelist_reply(cmd_t c);
    result_t r;
    logic [39:0] id;
    r.status = ST_PENDING;
    r.entry_index = '0;
    r.card_id = '0;
    if (hdr_pos < HDR_LEN) begin
      if (c.rx_byte == hdr_at(hdr_pos)) hdr_pos++;
      else hdr_pos = 0;
    end else begin
      id_bytes[id_cnt] = c.rx_byte;
      id_cnt++;
      if (id_cnt == ID_LEN) begin
        id = {id_bytes[0], id_bytes[1], id_bytes[2], id_bytes[3], id_bytes[4]};
        r.card_id = id;
        case (c.req_type)
          REQ_CHECK: begin
            r.status = ST_DENIED;
            for (int j = store_top; j >= 0; j--) begin
              if (id_store[j] == id) begin
                r.status = ST_GRANTED;
                r.entry_index = 4'(j);
              end
            end
          end
          REQ_ENROLL: begin
            if (store_top + 1 < TABLE_ENTRIES) begin
              store_top++;
              id_store[store_top] = id;
              known_ids.push_back(id);
              r.status = ST_ENROLLED;
              r.entry_index = 4'(store_top);
            end else begin
              r.status = ST_FULL;
            end
          end
          default: begin
            r.status = ST_DISCARD;
          end
        endcase
        hdr_pos = 0;
        id_cnt = 0;
      end
    end
    return r;
  endfunction

  function automatic logic [39:0] pick_card_id();
    int r;
    logic [39:0] id;
    r = $urandom_range(99);
    id = {8'($urandom), 32'($urandom)};
    if (r < 45) begin
      id = known_ids[$urandom_range(known_ids.size() - 1)];
    end else if (r < 55) begin
      id = known_ids[$urandom_range(known_ids.size() - 1)] ^ (40'd1 << $urandom_range(39));
    end else if (r < 65) begin
      for (int k = 0; k < ID_LEN; k++) id[k*8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return id;
  endfunction

  function automatic logic [1:0] pick_request();
    int r;
    r = $urandom_range(99);
    if (r < 68) return REQ_CHECK;
    else if (r < 78) return REQ_ENROLL;
    else if (r < 89) return REQ_DISCARD;
    else return REQ_UNUSED;
  endfunction

  // A beat is accepted at the edge where start is high and busy is low.
  task automatic send_byte(logic [7:0] b, logic [1:0] req);
    cmd_t c;
    c.rx_byte = b;
    c.req_type = req;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      cmd <= cmd_t'(10'($urandom));
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    reply_fifo.push_back(whitelist_reply(c));
    accepted_beats++;
  endtask

  task automatic send_frame(logic [39:0] id, logic [1:0] req);
    for (int k = 0; k < HDR_LEN; k++) send_byte(hdr_at(k), 2'($urandom));
    for (int k = 0; k < ID_LEN; k++) begin
      send_byte(id[(ID_LEN - 1 - k) * 8 +: 8], (k == ID_LEN - 1) ? req : 2'($urandom));
    end
  endtask

  task automatic test_header_restart();
    send_byte(8'h04, REQ_CHECK);
    send_byte(8'h0C, REQ_ENROLL);
    send_byte(8'h04, REQ_CHECK);
    send_byte(8'h0C, REQ_CHECK);
    send_frame(40'h00_0000_0000, REQ_CHECK);
  endtask

  task automatic test_id_extremes();
    send_frame(40'hFF_FFFF_FFFF, REQ_ENROLL);
    send_frame(40'hFF_FFFF_FFFF, REQ_CHECK);
    send_frame(40'h00_0000_00FF, REQ_CHECK);
  endtask

  task automatic test_unused_requests();
    send_frame(40'h5A_A5C3_3C81, REQ_DISCARD);
    send_frame(40'hFF_FFFF_FFFF, REQ_UNUSED);
  endtask

  task automatic test_duplicate_ids();
    send_frame(40'h12_3456_789A, REQ_ENROLL);
    send_frame(40'h12_3456_789A, REQ_ENROLL);
    send_frame(40'h12_3456_789A, REQ_CHECK);
  endtask

  task automatic test_table_full();
    while (store_top + 1 < TABLE_ENTRIES) send_frame(pick_card_id(), REQ_ENROLL);
    send_frame(pick_card_id(), REQ_ENROLL);
    send_frame(known_ids[$], REQ_CHECK);
  endtask

  task automatic test_random_traffic(int n_beats, int idle_pct);
    int first;
    int kind;
    int len;
    logic [7:0] b;
    sender_idle_pct = idle_pct;
    first = accepted_beats;
    while (accepted_beats - first < n_beats) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        send_frame(pick_card_id(), pick_request());
      end else if (kind < 90) begin
        len = $urandom_range(1, HDR_LEN - 1);
        for (int k = 0; k < len; k++) send_byte(hdr_at(k), 2'($urandom));
        do b = 8'($urandom); while (b == hdr_at(len));
        send_byte(b, 2'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 2'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (reply_fifo.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual status %0d index %0d id %h",
                 $time, result.status, result.entry_index, result.card_id);
      end else begin
        want = reply_fifo.pop_front();
        if (result.status <= ST_DISCARD) status_seen[int'(result.status)]++;
        if (result.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, result.status);
        end
        if (result.entry_index !== want.entry_index) begin
          errors++;
          $display("%0t: entry_index mismatch: expected %0d actual %0d",
                   $time, want.entry_index, result.entry_index);
        end
        if (result.card_id !== want.card_id) begin
          errors++;
          $display("%0t: card_id mismatch: expected %h actual %h",
                   $time, want.card_id, result.card_id);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, reply_fifo.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (id_store[i]) id_store[i] = '0;
    foreach (id_bytes[i]) id_bytes[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    known_ids.push_back(40'h00_0000_0000);
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_header_restart();
    test_id_extremes();
    test_unused_requests();
    test_duplicate_ids();
    test_random_traffic(600, 0);
    test_random_traffic(600, 56);
    test_table_full();
    test_random_traffic(550, 7);

    start <= 1'b0;
    while (reply_fifo.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 4) @(posedge clk);

    $display("Sent %0d reader bytes with and without sender gaps, table filled to %0d entries.",
             accepted_beats, store_top + 1);
    $display("Outcomes: %0d granted, %0d denied, %0d enrolled, %0d full, %0d discarded.",
             status_seen[1], status_seen[2], status_seen[3], status_seen[4], status_seen[5]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
